>>> rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; every other file in rtl/ imports this package.
package lkv_pkg;

    // Storage geometry
    localparam int ENTRIES = 16;
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int DATA_W  = 32;

    // Register file
    localparam int              ADDR_W       = 3;
    localparam logic            REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;

    // Operation codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic                     lookup;
        logic                     commit;
        logic                     is_hit;
        logic                     is_put;
        logic                     do_evict;
        logic                     ins_ok;
        logic [RANK_W-1:0]        hit_rank;
        logic [OCC_W-1:0]         cap_m1;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

    // Data handed from one cell to the next
    typedef struct packed {
        logic              hit;
        logic [RANK_W-1:0] rank;
        logic [DATA_W-1:0] value;
        logic              taken;
    } cell_chain_t;

    // Per-cell status seen by the controller
    typedef struct packed {
        logic valid;
        logic match;
    } cell_stat_t;

endpackage

>>> rtl/lkv_cell.sv
// One entry of the cache: key, value, valid mark and recency rank.
// Depends on lkv_pkg; chained with its neighbors in lru_key_value_cache.
module lkv_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lkv_pkg::cell_cmd_t   cmd,
    input  lkv_pkg::cell_chain_t chain_in,
    output lkv_pkg::cell_chain_t chain_out,
    output lkv_pkg::cell_stat_t  stat
);
    import lkv_pkg::*;

    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     valid_reg;
    logic [RANK_W-1:0]        rank_reg;
    logic                     match_reg;

    logic evict;
    logic live;
    logic grant;

    // Evict on a full insert, then claim the first free cell along the chain
    always_comb begin
        evict = cmd.do_evict && valid_reg && (OCC_W'(rank_reg) >= cmd.cap_m1);
        live  = valid_reg && !evict;
        grant = !live && !chain_in.taken;

        chain_out.hit   = chain_in.hit | match_reg;
        chain_out.rank  = chain_in.rank | (match_reg ? rank_reg : '0);
        chain_out.value = chain_in.value | (match_reg ? value_reg : '0);
        chain_out.taken = chain_in.taken | !live;

        stat.valid = valid_reg;
        stat.match = match_reg;
    end

    // Hold valid mark, rank and match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
        end else begin
            if (cmd.lookup) begin
                match_reg <= valid_reg && (key_reg == cmd.key);
            end
            if (cmd.commit) begin
                if (cmd.is_hit) begin
                    if (match_reg) begin
                        rank_reg <= '0;
                    end else if (valid_reg && (rank_reg < cmd.hit_rank)) begin
                        rank_reg <= rank_reg + RANK_W'(1);
                    end
                end else if (cmd.is_put) begin
                    if (grant && cmd.ins_ok) begin
                        valid_reg <= 1'b1;
                        rank_reg  <= '0;
                    end else if (evict) begin
                        valid_reg <= 1'b0;
                        rank_reg  <= '0;
                    end else if (valid_reg && cmd.ins_ok) begin
                        rank_reg <= rank_reg + RANK_W'(1);
                    end
                end
            end
        end
    end

    // Write key and value on insert, value on update
    always_ff @(posedge aclk) begin
        if (cmd.commit && cmd.is_put) begin
            if (cmd.is_hit && match_reg) begin
                value_reg <= cmd.value;
            end else if (!cmd.is_hit && grant) begin
                key_reg   <= cmd.key;
                value_reg <= cmd.value;
            end
        end
    end

endmodule

>>> rtl/lkv_apb_regs.sv
// APB-style register file holding the capacity register.
// Depends on lkv_pkg.
module lkv_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
    output logic [lkv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [lkv_pkg::CAP_W-1:0]   capacity
);
    import lkv_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             wr_en;

    // Decode the word index and the access phase
    always_comb begin
        pready   = 1'b1;
        wr_en    = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
        prdata   = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_reg) : '0;
        capacity = capacity_reg;
    end

    // Hold capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (wr_en) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

endmodule

>>> rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Input beat on s_valid/s_ready carries action (get or put), key and value.
// Result beat on m_valid/m_ready carries found and read_value (zero on a miss
// and on every put).
// Each operation passes through a lookup step, in which every cell compares its
// key and registers a match flag, and an update step, in which hit, rank, value
// and free-slot information ripple along the row of cells and every cell updates
// its rank. The result lands in an output register at the end of the update step.
// The next beat is taken in the same cycle as the update commits.
// While a result waits in the output register and m_ready is low, the update
// of the following operation holds until the register frees up, and s_ready
// stays low meanwhile, so no further input beat is taken.
// The user must set capacity over the APB port (address 0) only while the cache
// is idle; the block itself does not enforce this. Reset clears all valid marks,
// ranks and the occupancy count and sets the capacity to 16; keys and values stay
// unwritten until an insert.
module lru_key_value_cache (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lkv_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lkv_pkg::out_item_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkv_pkg::ADDR_W-1:0]  paddr,
    input  logic [lkv_pkg::DATA_W-1:0]  pwdata,
    output logic [lkv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import lkv_pkg::*;

    state_t           state_reg, state_next;
    in_item_t         op_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic [CAP_W-1:0] capacity;
    logic [CMP_W-1:0] cap_wide;
    logic [OCC_W-1:0] eff_cap;
    logic [OCC_W-1:0] cap_m1;

    cell_cmd_t        cmd;
    cell_chain_t      chain [ENTRIES+1];
    cell_stat_t       stat  [ENTRIES];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;

    logic accept;
    logic lookup;
    logic commit;
    logic hit;
    logic is_put;
    logic do_evict;
    logic ins_ok;
    logic out_free;

    lkv_apb_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // Row of entry cells
    assign chain[0] = '0;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat[g])
        );
        assign valid_vec[g] = stat[g].valid;
        assign match_vec[g] = stat[g].match;
    end

    // Clamp capacity to 1 .. ENTRIES
    always_comb begin
        cap_wide = CMP_W'(capacity);
        if (cap_wide == '0) begin
            eff_cap = OCC_W'(1);
        end else if (cap_wide > CMP_W'(ENTRIES)) begin
            eff_cap = OCC_W'(ENTRIES);
        end else begin
            eff_cap = OCC_W'(cap_wide);
        end
        cap_m1 = eff_cap - OCC_W'(1);
    end

    // Decode the operation against the end of the chain
    always_comb begin
        hit      = chain[ENTRIES].hit;
        is_put   = (op_reg.action == ACT_PUT);
        do_evict = !hit && is_put && (occ_reg >= eff_cap);
        ins_ok   = chain[ENTRIES].taken;
        out_free = !m_valid_reg || m_ready;

        cmd.lookup   = lookup;
        cmd.commit   = commit;
        cmd.is_hit   = hit;
        cmd.is_put   = is_put;
        cmd.do_evict = do_evict;
        cmd.ins_ok   = ins_ok;
        cmd.hit_rank = chain[ENTRIES].rank;
        cmd.cap_m1   = cap_m1;
        cmd.key      = op_reg.key;
        cmd.value    = op_reg.value;
    end

    // Sequence lookup and update
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        lookup     = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                lookup     = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    commit     = 1'b1;
                    s_ready    = 1'b1;
                    state_next = s_valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Track occupancy across inserts and evictions
    always_comb begin
        occ_next = occ_reg;
        if (commit && !hit && is_put) begin
            occ_next = (do_evict ? cap_m1 : occ_reg) + OCC_W'(ins_ok);
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the operation and the result beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= s_data;
        end
        if (commit) begin
            m_data_reg.found      <= hit;
            m_data_reg.read_value <= (hit && !is_put) ? chain[ENTRIES].value : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Occupancy always equals the number of valid cells
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == OCC_W'($countones(valid_vec)))
        else $error("occupancy differs from valid cell count");

    // Keys are unique, so at most one cell matches
    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // An insert always finds a free cell after eviction
    a_insert_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !hit && is_put) |-> ins_ok)
        else $error("insert found no free cell");

    // Every committed operation produces a result beat
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg)
        else $error("committed operation produced no result");

endmodule
